// ----- sv/rrts_pkg.sv -----
// rrts_pkg: shared types and constants of the round-robin task scheduler.
// Item and result beats, queue entry records and the FIFO control group.
// No dependencies.
`default_nettype none

package rrts_pkg;

	localparam int TIME_W              = 24;
	localparam int ID_W                = 8;
	localparam int BURST_W             = 16;
	localparam int QUANTUM_W           = 8;
	localparam int QUEUE_DEPTH_DEFAULT = 16;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

	// action codes
	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    task_id;
		logic [BURST_W-1:0] burst;
	} item_t;

	typedef struct packed {
		logic               rejected;
		logic               running_valid;
		logic [ID_W-1:0]    running_id;
		logic               switched;
		logic               finished;
		logic [ID_W-1:0]    finished_id;
		logic [TIME_W-1:0]  turnaround;
		logic [TIME_W-1:0]  waiting;
	} result_t;

	// new-task queue entry: remaining work equals burst until first run
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} new_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] left;
		logic [TIME_W-1:0]  arrival;
	} task_t;

	localparam int NEW_ENTRY_W = $bits(new_entry_t);
	localparam int TASK_W      = $bits(task_t);

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ----- sv/rrts_fifo.sv -----
// rrts_fifo: circular FIFO in a memory with a registered show-ahead head read.
// Depends on rrts_pkg (control and status structs).
`default_nettype none

module rrts_fifo #(
	parameter int DEPTH = rrts_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int WIDTH = rrts_pkg::TASK_W
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  rrts_pkg::fifo_ctrl_t    ctrl,
	input  wire  [WIDTH-1:0]        push_data,
	output logic [WIDTH-1:0]        head_data,
	output rrts_pkg::fifo_stat_t    stat
);
	import rrts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    head_nxt;
	logic [WIDTH-1:0] rd_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign head_nxt = ctrl.pop ? wrap_inc(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_nxt;
			if (ctrl.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// head read follows the next head pointer; a write landing there is bypassed
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= push_data;
		end
		if (ctrl.push && (tail_q == head_nxt)) begin
			rd_q <= push_data;
		end else begin
			rd_q <= mem[head_nxt];
		end
	end

	assign head_data  = rd_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

endmodule

`default_nettype wire

// ----- sv/rrts_core.sv -----
// rrts_core: dispatch, run and retire logic with time, current task and slice state.
// Depends on rrts_pkg; drives both queue FIFOs through fifo_ctrl_t.
`default_nettype none

module rrts_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	input  rrts_pkg::item_t                     item,
	input  wire  [rrts_pkg::QUANTUM_W-1:0]      quantum,
	input  rrts_pkg::fifo_stat_t                new_stat,
	input  rrts_pkg::new_entry_t                new_head,
	output rrts_pkg::fifo_ctrl_t                new_ctrl,
	output rrts_pkg::new_entry_t                new_push,
	input  rrts_pkg::fifo_stat_t                pre_stat,
	input  rrts_pkg::task_t                     pre_head,
	output rrts_pkg::fifo_ctrl_t                pre_ctrl,
	output rrts_pkg::task_t                     pre_push,
	output rrts_pkg::result_t                   result
);
	import rrts_pkg::*;

	logic [TIME_W-1:0]    time_q;
	task_t                cur_q;
	logic                 cur_valid_q;
	logic [QUANTUM_W-1:0] slice_q;

	logic                 is_arrive, is_tick;
	logic                 dispatch, from_new, run;
	task_t                task_sel;
	logic [QUANTUM_W-1:0] slice_load, slice_sel, slice_dec;
	logic [BURST_W-1:0]   left_dec;
	logic [TIME_W-1:0]    time_nxt, ta, wt;
	logic                 fin, expire, pre_room, push_pre;

	always_comb begin
		is_arrive = item_valid && (item.action == ACT_ARRIVE);
		is_tick   = item_valid && (item.action == ACT_TICK);

		slice_load = (quantum == '0) ? QUANTUM_W'(1) : quantum;

		dispatch = is_tick && !cur_valid_q && (!new_stat.empty || !pre_stat.empty);
		from_new = !new_stat.empty;

		if (!dispatch) begin
			task_sel = cur_q;
		end else if (from_new) begin
			task_sel = '{id: new_head.id, burst: new_head.burst,
				left: new_head.burst, arrival: new_head.arrival};
		end else begin
			task_sel = pre_head;
		end

		run       = is_tick && (cur_valid_q || dispatch);
		slice_sel = dispatch ? slice_load : slice_q;
		time_nxt  = time_q + TIME_W'(1);

		left_dec  = (task_sel.left != '0) ? task_sel.left - BURST_W'(1) : '0;
		slice_dec = (slice_sel != '0) ? slice_sel - QUANTUM_W'(1) : '0;

		fin    = run && (left_dec == '0);
		expire = run && !fin && (slice_dec == '0);
		ta     = time_nxt - task_sel.arrival;
		wt     = ta - TIME_W'(task_sel.burst);

		// a pop from the preempted queue in the same tick frees a slot
		pre_room = !pre_stat.full || (dispatch && !from_new);
		push_pre = expire && pre_room;

		new_ctrl.push = is_arrive && !new_stat.full;
		new_ctrl.pop  = dispatch && from_new;
		new_push      = '{id: item.task_id, burst: item.burst, arrival: time_q};

		pre_ctrl.push = push_pre;
		pre_ctrl.pop  = dispatch && !from_new;
		pre_push      = '{id: task_sel.id, burst: task_sel.burst,
			left: left_dec, arrival: task_sel.arrival};

		result               = '0;
		result.rejected      = is_arrive && new_stat.full;
		result.running_valid = run;
		result.switched      = dispatch;
		result.finished      = fin;
		if (run) begin
			result.running_id = task_sel.id;
		end
		if (fin) begin
			result.finished_id = task_sel.id;
			result.turnaround  = ta;
			result.waiting     = wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			slice_q     <= '0;
		end else if (is_tick) begin
			time_q <= time_nxt;
			if (run) begin
				cur_q       <= pre_push;
				cur_valid_q <= !fin && !push_pre;
				if (fin) begin
					slice_q <= '0;
				end else if (expire && !push_pre) begin
					slice_q <= slice_load;
				end else begin
					slice_q <= slice_dec;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/round_robin_task_scheduler.sv -----
// round_robin_task_scheduler: top level of the round-robin time-slice scheduler.
// Depends on rrts_pkg, rrts_fifo (new and preempted queues) and rrts_core.
//
// Usage notes
//  - Item channel: an item beat (item.action, item.task_id, item.burst) is taken
//    at each rising edge with start high and busy low. busy is always low, so
//    a beat may be offered every cycle: one item per cycle sustained.
//  - action arrive queues a task in the new-task FIFO stamped with the current
//    time; a full FIFO drops it and the result says rejected.
//  - action tick advances time one unit, dispatching first if nothing is
//    current (never-run tasks before preempted ones), then runs the task.
//  - Every item gives exactly one result beat. The item sits in the input
//    register, where the dispatch/run logic and the FIFO head reads resolve;
//    the result register then drives result with result_valid high for one
//    cycle.
//  - The receiver cannot stall: each result beat is shown for one cycle only.
//  - Config channel: cfg_data is the quantum, written when cfg_valid and
//    cfg_ready are high; cfg_ready is always high. A quantum of 0 acts as 1.
//    Write it only while no item is in flight.
//  - Reset (arst_n low) empties both FIFOs, clears time, the current task and
//    slice, and sets quantum to 4. No clearing pass: usable at once.
`default_nettype none

module round_robin_task_scheduler #(
	parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  rrts_pkg::item_t                 item,
	output logic                            result_valid,
	output rrts_pkg::result_t               result,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [rrts_pkg::QUANTUM_W-1:0]  cfg_data
);
	import rrts_pkg::*;

	logic                 valid_s1;
	item_t                item_s1;
	logic                 valid_s2;
	result_t              result_s2;
	logic [QUANTUM_W-1:0] quantum_q;

	fifo_ctrl_t new_ctrl, pre_ctrl;
	fifo_stat_t new_stat, pre_stat;
	new_entry_t new_head, new_push;
	task_t      pre_head, pre_push;
	result_t    result_comb;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	rrts_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (NEW_ENTRY_W)
	) u_new_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (new_ctrl),
		.push_data (new_push),
		.head_data (new_head),
		.stat      (new_stat)
	);

	rrts_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (TASK_W)
	) u_pre_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (pre_ctrl),
		.push_data (pre_push),
		.head_data (pre_head),
		.stat      (pre_stat)
	);

	rrts_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.quantum    (quantum_q),
		.new_stat   (new_stat),
		.new_head   (new_head),
		.new_ctrl   (new_ctrl),
		.new_push   (new_push),
		.pre_stat   (pre_stat),
		.pre_head   (pre_head),
		.pre_ctrl   (pre_ctrl),
		.pre_push   (pre_push),
		.result     (result_comb)
	);

	// result register: one beat per item, shown for a single cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// a rejected arrival never reports a running or finishing task
	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rejected |-> !result.running_valid && !result.finished)
		else $error("rejected arrival reported task activity");

	// completion only of the task that ran in that tick
	a_finish_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.finished |->
			result.running_valid && (result.finished_id == result.running_id))
		else $error("finished task differs from running task");

	// a dispatch always leads to a task running
	a_switch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.switched |-> result.running_valid)
		else $error("dispatch without a running task");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking bench for round_robin_task_scheduler.
// Holds a scheduler scoreboard (prediction and result checking) and the tasks that drive
// item and quantum beats. Depends on rrts_pkg and the scheduler RTL.

class sched_scoreboard;
	// predicted scheduler state
	rrts_pkg::task_t   fresh_q[$];    // tasks never yet run
	rrts_pkg::task_t   parked_q[$];   // preempted tasks
	rrts_pkg::task_t   cur;
	bit                cur_valid;
	logic [7:0]        slice;
	logic [7:0]        quantum;
	logic [23:0]       clock_now;
	int                depth;

	// results still to come, oldest first
	rrts_pkg::result_t due_q[$];

	int mismatches, checked;
	int arrivals, rejects, ticks, idle_ticks, switches, finishes, preempts, held_full;

	function new(int depth_i);
		depth     = depth_i;
		cur       = '0;
		cur_valid = 1'b0;
		slice     = '0;
		quantum   = rrts_pkg::QUANTUM_RESET;
		clock_now = '0;
	endfunction

	function logic [7:0] slice_reload();
		return (quantum == 8'd0) ? 8'd1 : quantum;
	endfunction

	// One scheduler step: applies an item to the predicted state and gives its result.
	function rrts_pkg::result_t schedule_step(rrts_pkg::item_t it);
		rrts_pkg::result_t r;
		rrts_pkg::task_t   t;
		logic [23:0]       ta;
		r = '0;
		if (it.action == rrts_pkg::ACT_ARRIVE) begin
			arrivals++;
			if (fresh_q.size() >= depth) begin
				r.rejected = 1'b1;
				rejects++;
			end else begin
				t.id      = it.task_id;
				t.burst   = it.burst;
				t.left    = it.burst;
				t.arrival = clock_now;
				fresh_q.insert(fresh_q.size(), t);
			end
			return r;
		end
		ticks++;
		if (!cur_valid) begin
			if (fresh_q.size() != 0) begin
				cur       = fresh_q.pop_front();
				cur_valid = 1'b1;
			end else if (parked_q.size() != 0) begin
				cur       = parked_q.pop_front();
				cur_valid = 1'b1;
			end
			if (cur_valid) begin
				slice      = slice_reload();
				r.switched = 1'b1;
				switches++;
			end
		end
		clock_now = clock_now + 24'd1;
		if (!cur_valid) begin
			idle_ticks++;
			return r;
		end
		r.running_valid = 1'b1;
		r.running_id    = cur.id;
		if (cur.left != 0)
			cur.left = cur.left - 16'd1;
		if (slice != 0)
			slice = slice - 8'd1;
		if (cur.left == 0) begin
			ta            = clock_now - cur.arrival;
			r.finished    = 1'b1;
			r.finished_id = cur.id;
			r.turnaround  = ta;
			r.waiting     = ta - {8'd0, cur.burst};
			cur_valid     = 1'b0;
			slice         = '0;
			finishes++;
		end else if (slice == 0) begin
			if (parked_q.size() < depth) begin
				parked_q.insert(parked_q.size(), cur);
				cur_valid = 1'b0;
				preempts++;
			end else begin
				// preempted queue full: task keeps the processor for another slice
				slice = slice_reload();
				held_full++;
			end
		end
		return r;
	endfunction

	function void note_item(rrts_pkg::item_t it);
		due_q.insert(due_q.size(), schedule_step(it));
	endfunction

	task report(string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result beat %0d: %s", checked, msg);
	endtask

	task cmp(string name, logic [23:0] got, logic [23:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task check_result(rrts_pkg::result_t got);
		rrts_pkg::result_t want;
		if (due_q.size() == 0) begin
			report("result beat with nothing outstanding");
			return;
		end
		want = due_q.pop_front();
		checked++;
		cmp("rejected",      24'(got.rejected),      24'(want.rejected));
		cmp("running_valid", 24'(got.running_valid), 24'(want.running_valid));
		cmp("running_id",    24'(got.running_id),    24'(want.running_id));
		cmp("switched",      24'(got.switched),      24'(want.switched));
		cmp("finished",      24'(got.finished),      24'(want.finished));
		cmp("finished_id",   24'(got.finished_id),   24'(want.finished_id));
		cmp("turnaround",    got.turnaround,         want.turnaround);
		cmp("waiting",       got.waiting,            want.waiting);
	endtask
endclass

module tb;
	import rrts_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEFAULT;
	localparam int STALL_LIMIT = 4000;   // cycles with no beat of any kind
	localparam int SETTLE      = 4;      // result follows the item through the input and result registers; margin

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	item_t                item      = '0;
	logic                 cfg_valid = 1'b0;
	logic [QUANTUM_W-1:0] cfg_data  = '0;
	logic                 busy;
	logic                 result_valid;
	logic                 cfg_ready;
	result_t              result;

	sched_scoreboard sb;
	int unsigned     stall_cycles = 0;

	always #1 clk = ~clk;

	round_robin_task_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Monitor: samples pre-edge values, so it sees exactly what the block took.
	// Results are checked before the new item is noted; a result can never belong
	// to the item accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && busy == 1'b0)
				sb.note_item(item);
			if (cfg_valid && cfg_ready)
				sb.quantum = cfg_data;
		end
	end

	// Watchdog: any beat in either direction resets the count.
	always @(posedge clk) begin
		if ((start && busy == 1'b0) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a beat", stall_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Lowers start for a gap of length n; start is only lowered when a gap is due,
	// so back-to-back beats keep it high.
	task automatic idle_for(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic write_quantum(logic [QUANTUM_W-1:0] q);
		cfg_valid <= 1'b1;
		cfg_data  <= q;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every predicted result has been seen, then a few spare cycles.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One phase at a fixed quantum. The phase is cut into spans, each with its own
	// mix: arrival storms (fill the new-task queue, hit rejection), tick runs (drain
	// and rotate), or the phase's own mix. Some spans run with no gaps at all.
	task automatic run_phase(logic [QUANTUM_W-1:0] q, int n, int arrive_pct,
			int max_burst);
		int    remaining, span, mode, pct, r, gap;
		bit    calm;
		item_t it;
		settle();
		write_quantum(q);
		remaining = n;
		while (remaining > 0) begin
			span = $urandom_range(10, 40);
			mode = $urandom_range(0, 9);
			calm = ($urandom_range(0, 3) == 0);
			pct  = (mode < 2) ? 90 : (mode < 4) ? 5 : arrive_pct;
			repeat (span) begin
				if (remaining > 0) begin
					if (!calm) begin
						r   = $urandom_range(0, 99);
						gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3)
							: $urandom_range(5, 40);
						idle_for(gap);
					end
					it.action  = ($urandom_range(0, 99) < pct) ? ACT_ARRIVE : ACT_TICK;
					it.task_id = 8'($urandom_range(0, 255));
					// now and then a full-range burst; these tasks linger, so keep them rare
					it.burst   = ($urandom_range(0, 299) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, max_burst));
					send_item(it);
					remaining--;
				end
			end
		end
	endtask

	initial begin
		sb = new(DEPTH);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset quantum of 4.
		send_item('{ACT_TICK,   8'hFF, 16'hFFFF});   // idle tick, ignored fields all ones
		send_item('{ACT_ARRIVE, 8'h00, 16'h0001});
		send_item('{ACT_ARRIVE, 8'hFF, 16'hFFFF});   // longest burst, rotates for good
		send_item('{ACT_ARRIVE, 8'hA5, 16'h0000});   // zero burst: one unit then done
		idle_for(3);
		send_item('{ACT_ARRIVE, 8'h5A, 16'h0006});
		repeat (9)
			send_item('{ACT_TICK, 8'h00, 16'h0000});

		// Random phases, quantum extremes among them (zero behaves as one).
		run_phase(8'd1,   250, 40, 12);
		run_phase(8'd255, 250, 35, 40);
		run_phase(8'd0,   200, 40, 6);
		run_phase(8'($urandom_range(2, 16)), 300, 35, 20);
		run_phase(8'd3,   300, 40, 10);
		// crowding at quantum 1: both queues fill, the preempted queue runs out of room
		run_phase(8'd1,   200, 65, 40);
		// mostly ticks to work the backlog off
		run_phase(8'($urandom_range(1, 255)), 250, 10, 16);
		settle();

		$display("covered %0d results: %0d arrivals (%0d turned away), %0d ticks (%0d idle)",
			sb.checked, sb.arrivals, sb.rejects, sb.ticks, sb.idle_ticks);
		$display("dispatches %0d, completions %0d, preemptions %0d, slices held on full queue %0d",
			sb.switches, sb.finishes, sb.preempts, sb.held_full);
		if (sb.mismatches == 0 && sb.due_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
